// ----- rtl/core/ppix_pkg.sv -----
// Shared constants, types and register codes for the perspective pixel projector.
package ppix_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 64;

  localparam int COL_W      = 8;
  localparam int ROW_W      = 6;
  localparam int IDX_W      = 14;
  localparam int POS_W      = 32;
  localparam int DIR_W      = 16;
  localparam int FOC_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int REL_W  = POS_W + 1;
  localparam int PROD_W = REL_W + DIR_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAG_W  = PROD_W;
  localparam int NUM_W  = 84;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int CRED_W = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_CAM_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 3'd6;

  localparam logic signed [DIR_W-1:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [DIR_W-1:0] NEG_ONE_Q14 = -16'sd16384;
  localparam logic [FOC_W-1:0]        FOCAL_RST   = 32'd1966080;

  typedef struct packed {
    logic signed [POS_W-1:0] cam_x;
    logic signed [POS_W-1:0] cam_y;
    logic signed [POS_W-1:0] cam_z;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [FOC_W-1:0]        focal;
  } cfg_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] rx;
    logic signed [DIR_W-1:0] ry;
    logic signed [DIR_W-1:0] rz;
    logic signed [DIR_W-1:0] ux;
    logic signed [DIR_W-1:0] uy;
    logic signed [DIR_W-1:0] uz;
  } axes_t;

  typedef struct packed {
    logic             dpos;
    logic             negx;
    logic             negy;
    logic [MAG_W-1:0] depth;
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
  } proj_t;

endpackage

// ----- rtl/core/ppix_point_if.sv -----
// Point word channel: valid, ready and one 3D point.
interface ppix_point_if;
  logic                             valid;
  logic                             ready;
  logic signed [ppix_pkg::POS_W-1:0] point_x;
  logic signed [ppix_pkg::POS_W-1:0] point_y;
  logic signed [ppix_pkg::POS_W-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

// ----- rtl/core/ppix_pixel_if.sv -----
// Pixel word channel: valid, ready and one projected screen position.
interface ppix_pixel_if;
  logic                        valid;
  logic                        ready;
  logic                        on_screen;
  logic [ppix_pkg::IDX_W-1:0]  pixel_index;
  logic [ppix_pkg::COL_W-1:0]  screen_col;
  logic [ppix_pkg::ROW_W-1:0]  screen_row;

  modport source (output valid, on_screen, pixel_index, screen_col, screen_row, input ready);
  modport sink (input valid, on_screen, pixel_index, screen_col, screen_row, output ready);
endinterface

// ----- rtl/core/ppix_axis.sv -----
// Configuration registers and sequential derivation of the camera right and up axes.
module ppix_axis (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ppix_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppix_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ppix_pkg::cfg_t                      cfg,
  output ppix_pkg::axes_t                     axes,
  output logic                                busy
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQRT = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_AXES = 3'd3;
  localparam logic [2:0] ST_UP   = 3'd4;

  localparam logic signed [15:0] ONE_Q14_L = ppix_pkg::ONE_Q14;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sh7fff;
    else if (v < -32'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] tdiv14(input logic signed [31:0] v);
    logic signed [31:0] m;
    m = v[31] ? -v : v;
    m = m >>> 14;
    return v[31] ? -m : m;
  endfunction

  logic        start;
  logic [2:0]  state;
  logic [29:0] sq_x;
  logic [29:0] sq_res;
  logic [3:0]  sq_k;
  logic [14:0] cx;
  logic [29:0] dvn_s;
  logic [29:0] dvn_c;
  logic [15:0] rs;
  logic [15:0] rc;
  logic [4:0]  dv_cnt;
  logic        neg_s;
  logic        neg_c;
  logic signed [15:0] sx;
  logic signed [15:0] sy;
  logic signed [15:0] cy;

  logic signed [31:0] t_init;
  logic [15:0]        mag_x;
  logic [15:0]        mag_z;
  logic [29:0]        bitv;
  logic [29:0]        trial;
  logic [29:0]        res_next;
  logic [29:0]        x_next;
  logic [15:0]        rs_sh;
  logic [15:0]        rc_sh;
  logic signed [31:0] qs;
  logic signed [31:0] qc;
  logic signed [31:0] ps;
  logic signed [31:0] pc;

  always_comb begin
    t_init = 32'sh1000_0000 - cfg.dir_y * cfg.dir_y;
    mag_x  = cfg.dir_x[15] ? 16'(-cfg.dir_x) : cfg.dir_x;
    mag_z  = cfg.dir_z[15] ? 16'(-cfg.dir_z) : cfg.dir_z;
    bitv   = 30'(1) << {sq_k, 1'b0};
    trial  = sq_res + bitv;
    if (sq_x >= trial) begin
      x_next   = sq_x - trial;
      res_next = (sq_res >> 1) + bitv;
    end else begin
      x_next   = sq_x;
      res_next = sq_res >> 1;
    end
    rs_sh = {rs[14:0], dvn_s[29]};
    rc_sh = {rc[14:0], dvn_c[29]};
    qs    = $signed({2'b00, dvn_s});
    qc    = $signed({2'b00, dvn_c});
    ps    = sx * sy;
    pc    = sx * cy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_x <= '0;
      cfg.cam_y <= '0;
      cfg.cam_z <= '0;
      cfg.dir_x <= '0;
      cfg.dir_y <= '0;
      cfg.dir_z <= ONE_Q14_L;
      cfg.focal <= ppix_pkg::FOCAL_RST;
      start     <= 1'b0;
    end else begin
      start <= cfg_we && (cfg_index inside {ppix_pkg::REG_DIR_X, ppix_pkg::REG_DIR_Y,
                                            ppix_pkg::REG_DIR_Z});
      if (cfg_we) begin
        case (cfg_index)
          ppix_pkg::REG_CAM_X: cfg.cam_x <= cfg_data;
          ppix_pkg::REG_CAM_Y: cfg.cam_y <= cfg_data;
          ppix_pkg::REG_CAM_Z: cfg.cam_z <= cfg_data;
          ppix_pkg::REG_DIR_X: cfg.dir_x <= cfg_data[15:0];
          ppix_pkg::REG_DIR_Y: cfg.dir_y <= cfg_data[15:0];
          ppix_pkg::REG_DIR_Z: cfg.dir_z <= cfg_data[15:0];
          ppix_pkg::REG_FOCAL: cfg.focal <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      axes.rx <= ppix_pkg::NEG_ONE_Q14;
      axes.ry <= '0;
      axes.rz <= '0;
      axes.ux <= '0;
      axes.uy <= ppix_pkg::NEG_ONE_Q14;
      axes.uz <= '0;
    end else if (start) begin
      state  <= ST_SQRT;
      sq_x   <= t_init[31] ? '0 : t_init[29:0];
      sq_res <= '0;
      sq_k   <= 4'd14;
      sx     <= cfg.dir_y;
      dvn_s  <= {mag_x, 14'b0};
      dvn_c  <= {mag_z, 14'b0};
      neg_s  <= cfg.dir_x[15];
      neg_c  <= !cfg.dir_z[15] && (cfg.dir_z != '0);
    end else begin
      case (state)
        ST_IDLE: ;
        ST_SQRT: begin
          sq_x   <= x_next;
          sq_res <= res_next;
          sq_k   <= sq_k - 4'd1;
          if (sq_k == 4'd0) begin
            cx     <= res_next[14:0];
            rs     <= '0;
            rc     <= '0;
            dv_cnt <= '0;
            state  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cx == '0) begin
            sy    <= '0;
            cy    <= ONE_Q14_L;
            state <= ST_UP;
          end else begin
            if (rs_sh >= {1'b0, cx}) begin
              rs    <= rs_sh - {1'b0, cx};
              dvn_s <= {dvn_s[28:0], 1'b1};
            end else begin
              rs    <= rs_sh;
              dvn_s <= {dvn_s[28:0], 1'b0};
            end
            if (rc_sh >= {1'b0, cx}) begin
              rc    <= rc_sh - {1'b0, cx};
              dvn_c <= {dvn_c[28:0], 1'b1};
            end else begin
              rc    <= rc_sh;
              dvn_c <= {dvn_c[28:0], 1'b0};
            end
            dv_cnt <= dv_cnt + 5'd1;
            if (dv_cnt == 5'd29) state <= ST_AXES;
          end
        end
        ST_AXES: begin
          sy    <= sat16(neg_s ? -qs : qs);
          cy    <= sat16(neg_c ? -qc : qc);
          state <= ST_UP;
        end
        ST_UP: begin
          axes.rx <= cy;
          axes.ry <= '0;
          axes.rz <= sy;
          axes.ux <= sat16(tdiv14(-ps));
          axes.uy <= sat16(-$signed({17'b0, cx}));
          axes.uz <= sat16(tdiv14(pc));
          state   <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = start || (state != ST_IDLE);

endmodule

// ----- rtl/core/ppix_front.sv -----
// Front end: accept points, form camera-relative dot products and classify depth and signs.
module ppix_front (
  input  logic            clk,
  input  logic            rst,
  ppix_point_if.sink      point,
  input  ppix_pkg::cfg_t  cfg,
  input  ppix_pkg::axes_t axes,
  input  logic            busy,
  input  logic            pop,
  output logic            push,
  output ppix_pkg::proj_t push_word
);

  logic [ppix_pkg::CRED_W-1:0] credit;
  logic                        acc;
  logic v1, v2, v3;

  logic signed [ppix_pkg::REL_W-1:0]  r_x, r_y, r_z;
  logic signed [ppix_pkg::PROD_W-1:0] pd_x, pd_y, pd_z;
  logic signed [ppix_pkg::PROD_W-1:0] pl_x, pl_y, pl_z;
  logic signed [ppix_pkg::PROD_W-1:0] pu_x, pu_y, pu_z;
  logic signed [ppix_pkg::SUM_W-1:0]  depth, lx, ly;
  logic signed [ppix_pkg::SUM_W-1:0]  lx_abs, ly_abs;

  assign point.ready = !busy && (credit < ppix_pkg::CRED_W'(ppix_pkg::QDEPTH));
  assign acc         = point.valid && point.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      push   <= 1'b0;
    end else begin
      credit <= credit + ppix_pkg::CRED_W'(acc) - ppix_pkg::CRED_W'(pop);
      v1     <= acc;
      v2     <= v1;
      v3     <= v2;
      push   <= v3;
    end
  end

  always_comb begin
    lx_abs = lx[ppix_pkg::SUM_W-1] ? -lx : lx;
    ly_abs = ly[ppix_pkg::SUM_W-1] ? -ly : ly;
  end

  always_ff @(posedge clk) begin
    r_x <= {point.point_x[ppix_pkg::POS_W-1], point.point_x}
         - {cfg.cam_x[ppix_pkg::POS_W-1], cfg.cam_x};
    r_y <= {point.point_y[ppix_pkg::POS_W-1], point.point_y}
         - {cfg.cam_y[ppix_pkg::POS_W-1], cfg.cam_y};
    r_z <= {point.point_z[ppix_pkg::POS_W-1], point.point_z}
         - {cfg.cam_z[ppix_pkg::POS_W-1], cfg.cam_z};

    pd_x <= r_x * cfg.dir_x;
    pd_y <= r_y * cfg.dir_y;
    pd_z <= r_z * cfg.dir_z;
    pl_x <= r_x * axes.rx;
    pl_y <= r_y * axes.ry;
    pl_z <= r_z * axes.rz;
    pu_x <= r_x * axes.ux;
    pu_y <= r_y * axes.uy;
    pu_z <= r_z * axes.uz;

    depth <= ppix_pkg::SUM_W'(pd_x) + ppix_pkg::SUM_W'(pd_y) + ppix_pkg::SUM_W'(pd_z);
    lx    <= ppix_pkg::SUM_W'(pl_x) + ppix_pkg::SUM_W'(pl_y) + ppix_pkg::SUM_W'(pl_z);
    ly    <= ppix_pkg::SUM_W'(pu_x) + ppix_pkg::SUM_W'(pu_y) + ppix_pkg::SUM_W'(pu_z);

    push_word.dpos  <= !depth[ppix_pkg::SUM_W-1] && (depth != '0);
    push_word.negx  <= lx[ppix_pkg::SUM_W-1];
    push_word.negy  <= ly[ppix_pkg::SUM_W-1];
    push_word.depth <= depth[ppix_pkg::MAG_W-1:0];
    push_word.mx    <= lx_abs[ppix_pkg::MAG_W-1:0];
    push_word.my    <= ly_abs[ppix_pkg::MAG_W-1:0];
  end

`ifndef SYNTH
  a_credit_max: assert property (@(posedge clk) disable iff (rst)
    credit <= ppix_pkg::CRED_W'(ppix_pkg::QDEPTH))
    else $error("front credit above queue depth");
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !point.ready)
    else $error("point taken during axis derivation");
`endif

endmodule

// ----- rtl/core/ppix_queue.sv -----
// Short word queue between the front end and the back end.
module ppix_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ppix_pkg::proj_t push_word,
  input  logic            pop,
  output logic            avail,
  output ppix_pkg::proj_t head
);

  ppix_pkg::proj_t             mem [ppix_pkg::QDEPTH];
  logic [ppix_pkg::QPTR_W-1:0] wr_ptr;
  logic [ppix_pkg::QPTR_W-1:0] rd_ptr;
  logic [ppix_pkg::CRED_W-1:0] cnt;

  assign avail = (cnt != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      cnt <= cnt + ppix_pkg::CRED_W'(push) - ppix_pkg::CRED_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_word;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt < ppix_pkg::CRED_W'(ppix_pkg::QDEPTH)) || pop)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != '0)
    else $error("queue underflow");
`endif

endmodule

// ----- rtl/core/ppix_back.sv -----
// Back end: focal scaling, screen offset, range checks and pipelined quotient per axis.
module ppix_back (
  input  logic                        clk,
  input  logic                        rst,
  input  ppix_pkg::proj_t             head,
  input  logic                        avail,
  output logic                        pop,
  input  logic [ppix_pkg::FOC_W-1:0]  focal,
  ppix_pixel_if.source                pixel
);

  localparam int NW    = ppix_pkg::NUM_W;
  localparam int CW    = ppix_pkg::COL_W;
  localparam int RW    = ppix_pkg::ROW_W;
  localparam int STEPS = CW;

  typedef struct packed {
    logic          ok;
    logic [NW-1:0] nc;
    logic [NW-1:0] nr;
    logic [NW-1:0] dd;
    logic [CW-1:0] qc;
    logic [RW-1:0] qr;
  } div_t;

  logic adv;
  logic v1, v2, v3, v4;
  logic [STEPS:0] dvv;
  div_t dv [STEPS+1];

  logic                        ok1, negx1, negy1;
  logic [ppix_pkg::MAG_W-1:0]  d1;
  logic [63:0]                 pxl, pyl;
  logic [48:0]                 pxh, pyh;

  logic          ok2, negx2, negy2;
  logic [NW-1:0] ax2, ay2, bc2, br2, dd2;

  logic          ok3, negx3, negy3;
  logic [NW-1:0] sumc3, sumr3, dd3, b2c3, b2r3;
  logic [NW:0]   difc3, difr3;

  logic          ok4;
  logic [NW-1:0] nc4, nr4, dd4, b2c4, b2r4;

  logic          spc, spr, okc, okr;
  logic [NW:0]   ambc, ambr;

  assign adv = !pixel.valid || pixel.ready;
  assign pop = adv && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      dvv         <= '0;
      pixel.valid <= 1'b0;
    end else if (adv) begin
      v1          <= pop;
      v2          <= v1;
      v3          <= v2;
      v4          <= v3;
      dvv         <= {dvv[STEPS-1:0], v4};
      pixel.valid <= dvv[STEPS];
    end
  end

  always_comb begin
    spc  = negx3 && (difc3[NW] || (difc3 == '0));
    spr  = negy3 && (difr3[NW] || (difr3 == '0));
    ambc = '0 - difc3;
    ambr = '0 - difr3;
    okc  = spc ? (ambc[NW-1:0] < dd3) : 1'b1;
    okr  = spr ? (ambr[NW-1:0] < dd3) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1   <= head.dpos;
      negx1 <= head.negx;
      negy1 <= head.negy;
      d1    <= head.depth;
      pxl   <= focal * head.mx[31:0];
      pxh   <= focal * head.mx[ppix_pkg::MAG_W-1:32];
      pyl   <= focal * head.my[31:0];
      pyh   <= focal * head.my[ppix_pkg::MAG_W-1:32];

      ok2   <= ok1;
      negx2 <= negx1;
      negy2 <= negy1;
      ax2   <= (NW'(pxh) << 33) + (NW'(pxl) << 1);
      ay2   <= (NW'(pyh) << 32) + NW'(pyl);
      bc2   <= (NW'(d1) * NW'(ppix_pkg::SCREEN_WIDTH)) << 16;
      br2   <= (NW'(d1) * NW'(ppix_pkg::SCREEN_HEIGHT)) << 16;
      dd2   <= NW'(d1) << 17;

      ok3   <= ok2;
      negx3 <= negx2;
      negy3 <= negy2;
      sumc3 <= ax2 + bc2;
      sumr3 <= ay2 + br2;
      difc3 <= {1'b0, bc2} - {1'b0, ax2};
      difr3 <= {1'b0, br2} - {1'b0, ay2};
      dd3   <= dd2;
      b2c3  <= bc2 << 1;
      b2r3  <= br2 << 1;

      ok4  <= ok3 && okc && okr;
      nc4  <= spc ? '0 : (negx3 ? difc3[NW-1:0] : sumc3);
      nr4  <= spr ? '0 : (negy3 ? difr3[NW-1:0] : sumr3);
      dd4  <= dd3;
      b2c4 <= b2c3;
      b2r4 <= b2r3;

      dv[0].ok <= ok4 && (nc4 < b2c4) && (nr4 < b2r4);
      dv[0].nc <= nc4;
      dv[0].nr <= nr4;
      dv[0].dd <= dd4;
      dv[0].qc <= '0;
      dv[0].qr <= '0;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_div
    localparam int KC = CW - 1 - j;
    div_t          nx;
    logic [NW-1:0] nr_n;
    logic [RW-1:0] qr_n;

    if (j < RW) begin : g_row
      localparam int KR = RW - 1 - j;
      always_comb begin
        nr_n = dv[j].nr;
        qr_n = dv[j].qr;
        if (dv[j].nr >= (dv[j].dd << KR)) begin
          nr_n     = dv[j].nr - (dv[j].dd << KR);
          qr_n[KR] = 1'b1;
        end
      end
    end else begin : g_pass
      assign nr_n = dv[j].nr;
      assign qr_n = dv[j].qr;
    end

    always_comb begin
      nx    = dv[j];
      nx.nr = nr_n;
      nx.qr = qr_n;
      if (dv[j].nc >= (dv[j].dd << KC)) begin
        nx.nc     = dv[j].nc - (dv[j].dd << KC);
        nx.qc[KC] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) dv[j+1] <= nx;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel.on_screen   <= dv[STEPS].ok;
      pixel.screen_col  <= dv[STEPS].ok ? dv[STEPS].qc : '0;
      pixel.screen_row  <= dv[STEPS].ok ? dv[STEPS].qr : '0;
      pixel.pixel_index <= dv[STEPS].ok
        ? ppix_pkg::IDX_W'(dv[STEPS].qc)
          + ppix_pkg::IDX_W'(dv[STEPS].qr) * ppix_pkg::IDX_W'(ppix_pkg::SCREEN_WIDTH)
        : '0;
    end
  end

`ifndef SYNTH
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && !pixel.on_screen |->
      pixel.pixel_index == '0 && pixel.screen_col == '0 && pixel.screen_row == '0)
    else $error("off-screen word carries a position");
`endif

endmodule

// ----- rtl/core/perspective_point_to_pixel_index.sv -----
// Top level of the pinhole perspective projector from 3D point to pixel index.
//
//   channel  | dir | handshake    | word
//   point    | in  | valid/ready  | point_x, point_y, point_z
//   pixel    | out | valid/ready  | on_screen, pixel_index, screen_col, screen_row
//   cfg      | in  | cfg_we       | cfg_index, cfg_data
//
// One point per cycle while point.ready is high (no axis rebuild, queue credit free); a point
// passes the front pipeline, the queue and the back pipeline. A direction write holds
// point.ready low while the shared sqrt and divide sequencer rebuilds the axes (the divide is
// skipped when the derived cx is zero); camera and focal writes take effect at once.
// Reset is synchronous; the axes come out of reset already derived.
// A stalled pixel port freezes the back pipeline; the 8-entry queue keeps the front going.
module perspective_point_to_pixel_index (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ppix_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppix_pkg::CFG_DATA_W-1:0] cfg_data,
  ppix_point_if.sink                      point,
  ppix_pixel_if.source                    pixel
);

  ppix_pkg::cfg_t  cfg;
  ppix_pkg::axes_t axes;
  ppix_pkg::proj_t push_word;
  ppix_pkg::proj_t head;
  logic            busy;
  logic            push;
  logic            pop;
  logic            avail;

  ppix_axis u_axis (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .axes      (axes),
    .busy      (busy)
  );

  ppix_front u_front (
    .clk       (clk),
    .rst       (rst),
    .point     (point),
    .cfg       (cfg),
    .axes      (axes),
    .busy      (busy),
    .pop       (pop),
    .push      (push),
    .push_word (push_word)
  );

  ppix_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .avail     (avail),
    .head      (head)
  );

  ppix_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .avail (avail),
    .pop   (pop),
    .focal (cfg.focal),
    .pixel (pixel)
  );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the pinhole perspective projector: directed and random points.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ppix_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int N_RANDOM = 1750;
  localparam int PHASES   = 6;

  typedef struct packed {
    logic                       vis;
    logic [ppix_pkg::IDX_W-1:0] idx;
    logic [ppix_pkg::COL_W-1:0] col;
    logic [ppix_pkg::ROW_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic signed [ppix_pkg::POS_W-1:0] x;
    logic signed [ppix_pkg::POS_W-1:0] y;
    logic signed [ppix_pkg::POS_W-1:0] z;
    logic                              typed;
    pixel_t                            res;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [ppix_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ppix_pkg::CFG_DATA_W-1:0] cfg_data;

  ppix_point_if point ();
  ppix_pixel_if pixel ();

  perspective_point_to_pixel_index u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .point(point), .pixel(pixel)
  );

  // camera model
  logic signed [ppix_pkg::POS_W-1:0] cam [3];
  logic signed [ppix_pkg::DIR_W-1:0] dir [3];
  logic [ppix_pkg::FOC_W-1:0]        focal;
  int right_ax [3];
  int up_ax [3];

  pixel_t pixel_due [$];
  logic   typed_due [$];
  pixel_t typed_val [$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;

  function automatic int sat16(int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic int floor_sqrt(longint v);
    longint r = 0;
    for (int b = 15; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r = r | (64'd1 << b);
    end
    return int'(r);
  endfunction

  task automatic rebuild_axes();
    int dx, sx, dz, t, cx, sy, cy;
    dx = dir[0];
    sx = dir[1];
    dz = dir[2];
    t = (1 << 28) - sx * sx;
    cx = floor_sqrt(t > 0 ? t : 0);
    if (cx != 0) begin
      sy = sat16((dx * 16384) / cx);
      cy = sat16((-dz * 16384) / cx);
    end else begin
      sy = 0;
      cy = 16384;
    end
    right_ax[0] = cy; right_ax[1] = 0; right_ax[2] = sy;
    up_ax[0] = sat16((-(sx * sy)) / 16384);
    up_ax[1] = sat16(-cx);
    up_ax[2] = sat16((sx * cy) / 16384);
  endtask

  task automatic model_write(logic [ppix_pkg::CFG_IDX_W-1:0] idx,
                             logic [ppix_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ppix_pkg::REG_CAM_X: cam[0] = data;
      ppix_pkg::REG_CAM_Y: cam[1] = data;
      ppix_pkg::REG_CAM_Z: cam[2] = data;
      ppix_pkg::REG_DIR_X: begin dir[0] = data[ppix_pkg::DIR_W-1:0]; rebuild_axes(); end
      ppix_pkg::REG_DIR_Y: begin dir[1] = data[ppix_pkg::DIR_W-1:0]; rebuild_axes(); end
      ppix_pkg::REG_DIR_Z: begin dir[2] = data[ppix_pkg::DIR_W-1:0]; rebuild_axes(); end
      ppix_pkg::REG_FOCAL: focal = data;
      default: ;
    endcase
  endtask

  function automatic logic screen_coord(logic signed [127:0] num, logic signed [127:0] depth,
                                        int limit, output int coord);
    logic signed [127:0] den, q;
    den = depth <<< 17;
    coord = 0;
    if (num <= -den) return 1'b0;
    q = num / den;
    if (q >= limit) return 1'b0;
    coord = int'(q);
    return 1'b1;
  endfunction

  function automatic pixel_t project(logic signed [ppix_pkg::POS_W-1:0] px,
                                     logic signed [ppix_pkg::POS_W-1:0] py,
                                     logic signed [ppix_pkg::POS_W-1:0] pz);
    longint r [3];
    longint depth, lx, ly;
    logic signed [127:0] fw, dw, lxw, lyw;
    int col, row;
    logic okc, okr;
    pixel_t p;
    r[0] = longint'(px) - longint'(cam[0]);
    r[1] = longint'(py) - longint'(cam[1]);
    r[2] = longint'(pz) - longint'(cam[2]);
    depth = 0; lx = 0; ly = 0;
    for (int i = 0; i < 3; i++) begin
      depth += r[i] * longint'(dir[i]);
      lx += r[i] * longint'(right_ax[i]);
      ly += r[i] * longint'(up_ax[i]);
    end
    p = '0;
    if (depth > 0) begin
      fw = {96'd0, focal};
      dw = depth;
      lxw = lx;
      lyw = ly;
      okc = screen_coord(2 * fw * lxw + (dw <<< 24), dw, ppix_pkg::SCREEN_WIDTH, col);
      okr = screen_coord(fw * lyw + (dw <<< 22), dw, ppix_pkg::SCREEN_HEIGHT, row);
      if (okc && okr) begin
        p.vis = 1'b1;
        p.col = col[ppix_pkg::COL_W-1:0];
        p.row = row[ppix_pkg::ROW_W-1:0];
        p.idx = ppix_pkg::IDX_W'(col + row * ppix_pkg::SCREEN_WIDTH);
      end
    end
    return p;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    pixel.ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    pixel_t p;
    if (!rst && point.valid && point.ready) begin
      p = project(point.point_x, point.point_y, point.point_z);
      if (typed_due.pop_front()) p = typed_val.pop_front();
      pixel_due.push_back(p);
    end
  end

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && pixel.valid && pixel.ready) begin
      got = '{pixel.on_screen, pixel.pixel_index, pixel.screen_col, pixel.screen_row};
      if (pixel_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel word %p", got);
      end else begin
        want = pixel_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("pixel mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic send_point(logic signed [ppix_pkg::POS_W-1:0] x,
                            logic signed [ppix_pkg::POS_W-1:0] y,
                            logic signed [ppix_pkg::POS_W-1:0] z, logic typed, pixel_t res);
    while ($urandom_range(99) < snd_idle) begin
      point.valid <= 1'b0;
      @(posedge clk);
    end
    typed_due.push_back(typed);
    if (typed) typed_val.push_back(res);
    point.valid   <= 1'b1;
    point.point_x <= x;
    point.point_y <= y;
    point.point_z <= z;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
  endtask

  task automatic drain();
    point.valid <= 1'b0;
    while (pixel_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_setting(logic [ppix_pkg::CFG_DATA_W-1:0] vals [7], logic extra);
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= ppix_pkg::CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      model_write(ppix_pkg::CFG_IDX_W'(i), vals[i]);
      @(posedge clk);
    end
    if (extra) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_signed(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic random_point(output logic signed [ppix_pkg::POS_W-1:0] x,
                              output logic signed [ppix_pkg::POS_W-1:0] y,
                              output logic signed [ppix_pkg::POS_W-1:0] z);
    longint t, lat;
    longint c [3];
    int kind;
    kind = $urandom_range(99);
    if (kind < 15) begin
      x = $urandom; y = $urandom; z = $urandom;
    end else begin
      t = longint'($urandom_range(1 << 22)) + 1;
      if (kind < 20) t = -t;
      lat = (t < 0 ? -t : t) >>> 2;
      for (int i = 0; i < 3; i++)
        c[i] = longint'(cam[i]) + ((longint'(dir[i]) * t) >>> 14) +
               longint'($urandom_range(2 * lat)) - lat;
      x = c[0][31:0]; y = c[1][31:0]; z = c[2][31:0];
    end
  endtask

  row_t plan [12];

  initial begin
    logic [ppix_pkg::CFG_DATA_W-1:0] vals [7];
    logic signed [ppix_pkg::POS_W-1:0] x, y, z;
    int ux, uy, uz, sent;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    point.valid = 1'b0; point.point_x = '0; point.point_y = '0; point.point_z = '0;
    pixel.ready = 1'b0;
    cam[0] = '0; cam[1] = '0; cam[2] = '0;
    dir[0] = '0; dir[1] = '0; dir[2] = ppix_pkg::ONE_Q14;
    focal = ppix_pkg::FOCAL_RST;
    rebuild_axes();
    plan = '{
      '{32'sd0, 32'sd0, 32'sd0, 1'b1, '{1'b0, 14'd0, 8'd0, 6'd0}},
      '{32'sd0, 32'sd0, -32'sd65536, 1'b1, '{1'b0, 14'd0, 8'd0, 6'd0}},
      '{32'sd0, 32'sd0, 32'sd65536, 1'b1, '{1'b1, 14'd8320, 8'd128, 6'd32}},
      '{32'sd0, 32'sd0, 32'sh7FFFFFFF, 1'b1, '{1'b1, 14'd8320, 8'd128, 6'd32}},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1, '{1'b0, 14'd0, 8'd0, 6'd0}},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, '0},
      '{32'sd280713, 32'sd0, 32'sd65536, 1'b0, '0},
      '{32'sd0, 32'sd140000, 32'sd65536, 1'b0, '0},
      '{-32'sd279000, 32'sd0, 32'sd65536, 1'b0, '0},
      '{32'sd0, -32'sd139810, 32'sd65536, 1'b0, '0},
      '{32'sd327680, 32'sd0, 32'sd65536, 1'b0, '0},
      '{32'sh80000000, 32'sh7FFFFFFF, 32'sd1, 1'b0, '0}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle = 38; rcv_idle = 87;
    foreach (plan[i]) send_point(plan[i].x, plan[i].y, plan[i].z, plan[i].typed, plan[i].res);
    drain();

    sent = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      ux = rand_signed(16384);
      uy = rand_signed(floor_sqrt((1 << 28) - ux * ux));
      uz = floor_sqrt((1 << 28) - ux * ux - uy * uy);
      if ($urandom_range(1)) uz = -uz;
      vals[0] = rand_signed(1 << 22);
      vals[1] = rand_signed(1 << 22);
      vals[2] = rand_signed(1 << 22);
      vals[3] = {16'($urandom), 16'(ux)};
      vals[4] = {16'($urandom), 16'(uy)};
      vals[5] = {16'($urandom), 16'(uz)};
      vals[6] = $urandom_range(1 << 23);
      case (ph)
        0: begin
          vals[3] = 32'(ppix_pkg::ONE_Q14); vals[4] = '0; vals[5] = '0;
          vals[6] = ppix_pkg::FOCAL_RST;
        end
        1: begin vals[3] = '0; vals[4] = 32'hFFFF0000 | 32'(ppix_pkg::ONE_Q14); vals[5] = '0; end
        2: begin
          vals[0] = 32'h7FFFFFFF; vals[1] = 32'h80000000; vals[2] = 32'h7FFFFFFF;
          vals[3] = 32'h00007FFF; vals[4] = 32'h00008000; vals[5] = 32'h00003039;
        end
        3: vals[6] = '0;
        4: begin
          vals[6] = 32'hFFFFFFFF; vals[0] = 32'h80000000;
          vals[3] = {16'hFFFF, 16'(16'sd9000)};
          vals[4] = {16'h0000, ppix_pkg::NEG_ONE_Q14 + 16'sd4000};
          vals[5] = {16'h5A5A, 16'sd20000};
        end
        default: ;
      endcase
      write_setting(vals, ph == 0);
      for (int k = 0; k < N_RANDOM / PHASES; k++) begin
        if (sent < N_RANDOM / 3) begin snd_idle = 38; rcv_idle = 87; end
        else if (sent < 2 * N_RANDOM / 3) begin snd_idle = 87; rcv_idle = 38; end
        else begin snd_idle = 0; rcv_idle = 0; end
        random_point(x, y, z);
        send_point(x, y, z, 1'b0, '0);
        sent++;
      end
      drain();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
